### design/hqe_pkg.sv
// Shared constants, widths and types for the histogram equaliser.
// No dependencies; imported by hqe_divider and histogram_equalizer_8bit.
package hqe_pkg;

   localparam int MAX_PIXELS = 65536;
   localparam int NUM_BINS   = 256;
   localparam int PIX_W      = 8;
   localparam int TOTAL_W    = $clog2(MAX_PIXELS + 1);
   // 510*cum + N stays below 512*N
   localparam int NUM_W      = TOTAL_W + 9;
   localparam int DEN_W      = TOTAL_W + 1;
   localparam int STEP_W     = $clog2(PIX_W);

   localparam logic REQ_COUNT = 1'b0;
   localparam logic REQ_REMAP = 1'b1;

   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] quotient;
   } div_stat_type;

endpackage

### design/hqe_divider.sv
// Restoring divider, one quotient bit per cycle, for the mapping table build.
// Depends on hqe_pkg for widths and the status struct.
module hqe_divider import hqe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output div_stat_type     stat
);

   logic [NUM_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [PIX_W-1:0]  quo_ff, quo_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [NUM_W-1:0]  den_sh;
   logic              fit;

   always_comb begin
      den_sh = NUM_W'(den_ff) << step_ff;
      fit    = (rem_ff >= den_sh);
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den;
         step_in = STEP_W'(PIX_W - 1);
         quo_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fit) begin
            rem_in = rem_ff - den_sh;
         end
         quo_in = {quo_ff[PIX_W-2:0], fit};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
      quo_ff  <= quo_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

### design/histogram_equalizer_8bit.sv
// Top level of the two-pass histogram equaliser: sequencer, bin and map memories.
// Depends on hqe_pkg and hqe_divider.
//
// Usage: words arrive on req_ (valid/stall); req_type selects count or remap.
// A count word adds req_pixel to the 256-bin histogram; the first count word after
// a closed pass clears the histogram. The count word with req_last set closes the
// pass: the block then builds the mapping table bin by bin and returns one rsp_
// word with mapped pixel 0 and the saturation flag. A remap word returns the
// equalised pixel through the table (identity until a pass has closed).
// Sequence: a count word passes through ST_CNT unless the pixel limit drops it;
// a remap word passes through ST_RMP, which registers its rsp word once the rsp
// register is free. The table build handles each bin in turn: memory read,
// accumulate, one divider start and 8 divider steps plus done. req_stall is
// high whenever the sequencer is busy.
// If rsp_stall holds a result, a further count word without last is still taken;
// a word that produces a result waits until the rsp register is free.
// Reset clears the histogram (through valid bits), the total and the flags,
// and restores the identity table at once; no clearing pass is needed.
module histogram_equalizer_8bit import hqe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_type,
   input  logic [PIX_W-1:0] req_pixel,
   input  logic             req_last,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_mapped_pixel,
   output logic             rsp_count_saturated
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CNT   = 3'd1;
   localparam logic [2:0] ST_BRD   = 3'd2;
   localparam logic [2:0] ST_BACC  = 3'd3;
   localparam logic [2:0] ST_BDIV  = 3'd4;
   localparam logic [2:0] ST_BWAIT = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;
   localparam logic [2:0] ST_RMP   = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic                pass_open_ff, pass_open_in;
   logic                sat_ff, sat_in;
   logic                built_ff, built_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [TOTAL_W-1:0]  cum_ff, cum_in;
   logic [PIX_W-1:0]    bin_idx_ff, bin_idx_in;
   logic [PIX_W-1:0]    pix_ff, pix_in;
   logic                last_ff, last_in;
   logic [NUM_BINS-1:0] bin_vld_ff, bin_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]    rsp_pix_ff, rsp_pix_in;
   logic                rsp_sat_ff, rsp_sat_in;

   logic [TOTAL_W-1:0]  bin_mem [NUM_BINS];
   logic [TOTAL_W-1:0]  bin_rd_ff;
   logic                bin_re, bin_we;
   logic [PIX_W-1:0]    bin_raddr, bin_waddr;
   logic [TOTAL_W-1:0]  bin_wdata;

   logic [PIX_W-1:0]    map_mem [NUM_BINS];
   logic [PIX_W-1:0]    map_rd_ff;
   logic                map_re, map_we;
   logic [PIX_W-1:0]    map_wdata;

   logic                div_start;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   div_stat_type        div_stat;

   logic                rsp_free;
   logic [TOTAL_W-1:0]  total_eff;
   logic                advance;

   hqe_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .stat  (div_stat)
   );

   // 510*cum + N and 2N
   assign div_num = {cum_ff, 9'b0} - NUM_W'({cum_ff, 1'b0}) + NUM_W'(total_ff);
   assign div_den = {total_ff, 1'b0};

   always_comb begin
      state_in     = state_ff;
      pass_open_in = pass_open_ff;
      sat_in       = sat_ff;
      built_in     = built_ff;
      total_in     = total_ff;
      cum_in       = cum_ff;
      bin_idx_in   = bin_idx_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      bin_vld_in   = bin_vld_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_sat_in   = rsp_sat_ff;
      bin_re       = 1'b0;
      bin_raddr    = req_pixel;
      bin_we       = 1'b0;
      bin_waddr    = pix_ff;
      bin_wdata    = (bin_vld_ff[pix_ff] ? bin_rd_ff : '0) + 1'b1;
      map_re       = 1'b0;
      map_we       = 1'b0;
      map_wdata    = div_stat.quotient;
      div_start    = 1'b0;
      advance      = 1'b0;

      rsp_free  = !rsp_valid_ff || !rsp_stall;
      total_eff = pass_open_ff ? total_ff : '0;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pix_in     = req_pixel;
               last_in    = req_last;
               bin_idx_in = '0;
               cum_in     = '0;
               if (req_type == REQ_REMAP) begin
                  map_re   = 1'b1;
                  state_in = ST_RMP;
               end else begin
                  if (!pass_open_ff) begin
                     bin_vld_in   = '0;
                     total_in     = '0;
                     sat_in       = 1'b0;
                     pass_open_in = 1'b1;
                  end
                  if (total_eff < TOTAL_W'(MAX_PIXELS)) begin
                     bin_re   = 1'b1;
                     state_in = ST_CNT;
                  end else begin
                     // drop the pixel
                     sat_in   = 1'b1;
                     state_in = req_last ? ST_BRD : ST_IDLE;
                  end
               end
            end
         end
         ST_CNT: begin
            bin_we             = 1'b1;
            bin_vld_in[pix_ff] = 1'b1;
            total_in           = total_ff + 1'b1;
            state_in           = last_ff ? ST_BRD : ST_IDLE;
         end
         ST_BRD: begin
            bin_re    = 1'b1;
            bin_raddr = bin_idx_ff;
            state_in  = ST_BACC;
         end
         ST_BACC: begin
            cum_in   = cum_ff + (bin_vld_ff[bin_idx_ff] ? bin_rd_ff : '0);
            state_in = ST_BDIV;
         end
         ST_BDIV: begin
            if (total_ff == '0) begin
               map_we    = 1'b1;
               map_wdata = bin_idx_ff;
               advance   = 1'b1;
            end else begin
               div_start = 1'b1;
               state_in  = ST_BWAIT;
            end
         end
         ST_BWAIT: begin
            if (div_stat.done) begin
               map_we  = 1'b1;
               advance = 1'b1;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = '0;
               rsp_sat_in   = sat_ff;
               pass_open_in = 1'b0;
               built_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RMP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = built_ff ? map_rd_ff : pix_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         if (bin_idx_ff == PIX_W'(NUM_BINS - 1)) begin
            state_in = ST_FIN;
         end else begin
            bin_idx_in = bin_idx_ff + 1'b1;
            state_in   = ST_BRD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_open_ff <= 1'b0;
         sat_ff       <= 1'b0;
         built_ff     <= 1'b0;
         total_ff     <= '0;
         bin_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_open_ff <= pass_open_in;
         sat_ff       <= sat_in;
         built_ff     <= built_in;
         total_ff     <= total_in;
         bin_vld_ff   <= bin_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cum_ff     <= cum_in;
      bin_idx_ff <= bin_idx_in;
      pix_ff     <= pix_in;
      last_ff    <= last_in;
      rsp_pix_ff <= rsp_pix_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[bin_waddr] <= bin_wdata;
      end
      if (bin_re) begin
         bin_rd_ff <= bin_mem[bin_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[bin_idx_ff] <= map_wdata;
      end
      if (map_re) begin
         map_rd_ff <= map_mem[req_pixel];
      end
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_mapped_pixel    = rsp_pix_ff;
   assign rsp_count_saturated = rsp_sat_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN || $past(state_ff) == ST_RMP))
      else $error("result word raised outside a result state");

   a_sat_total: assert property (@(posedge clock) disable iff (reset)
      sat_ff |-> (total_ff == TOTAL_W'(MAX_PIXELS)))
      else $error("saturation flag set below the pixel limit");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == ST_BWAIT && !div_stat.done))
      else $error("divider start not followed by wait");

   a_build_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BWAIT || state_ff == ST_FIN) |-> pass_open_ff)
      else $error("table build with no open pass");

endmodule
